// ===== src/pgfs_pkg.sv =====
`timescale 1ns / 1ps

package pgfs_pkg;

	localparam int DEF_SCREEN_COLUMNS = 256;
	localparam int DEF_SCREEN_PAGES   = 24;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DOT   = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] pos_x;
		logic [6:0] pos_y;
		logic [8:0] span_x;
		logic [6:0] span_y;
		logic [1:0] color;
	} cmd_t;

	// grey level repeated over the four pixel slots of a byte
	function automatic logic [7:0] grey_byte(input logic [1:0] c);
		return {4{c}};
	endfunction

endpackage

// ===== src/pgfs_ram.sv =====
`timescale 1ns / 1ps

module pgfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 6144,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pgfs_engine.sv =====
`timescale 1ns / 1ps

module pgfs_engine #(
	parameter int SCREEN_COLUMNS = pgfs_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_PAGES   = pgfs_pkg::DEF_SCREEN_PAGES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  pgfs_pkg::cmd_t cmd,
	output logic           cmd_ready,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [7:0]     res_byte
);

	localparam int DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CA_W  = $clog2(SCREEN_COLUMNS);
	localparam int PG_W  = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
	localparam int XW    = $clog2(SCREEN_COLUMNS + 1);
	localparam int XS_W  = (XW > 10) ? XW : 10;
	localparam logic [XS_W-1:0] COLS_X = XS_W'(SCREEN_COLUMNS);
	localparam logic [8:0]      ROWS9  = 9'(4 * SCREEN_PAGES);
	localparam logic [AW-1:0]   LAST_A = AW'(DEPTH - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLR   = 3'd1;
	localparam logic [2:0] ST_FSET  = 3'd2;
	localparam logic [2:0] ST_FPAGE = 3'd3;
	localparam logic [2:0] ST_FCOL  = 3'd4;
	localparam logic [2:0] ST_RD    = 3'd5;
	localparam logic [2:0] ST_RCAP  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]      state_q;
	logic            init_q;
	logic [1:0]      op_q;
	logic [7:0]      px_q;
	logic [6:0]      py_q;
	logic [8:0]      sx_q;
	logic [6:0]      sy_q;
	logic [7:0]      pat_q;
	logic [XS_W-1:0] xend_q;
	logic [8:0]      yend_q;
	logic [PG_W-1:0] page_q;
	logic [PG_W-1:0] pend_q;
	logic [XS_W-1:0] col_q;
	logic [7:0]      mask_q;
	logic            pend_s1;
	logic [AW-1:0]   waddr_s1;
	logic [AW-1:0]   clr_q;
	logic [7:0]      rbyte_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;

	logic [XS_W-1:0] px_x;
	logic [XS_W-1:0] x_sum;
	logic [XS_W-1:0] x_clip;
	logic [8:0]      y_sum;
	logic [8:0]      y_clip;
	logic [8:0]      y_last;
	logic [6:0]      pg7_first;
	logic [6:0]      pg7_last;
	logic [PG_W-1:0] page_first;
	logic            on_screen;
	logic            empty;
	logic [8:0]      base_row;
	logic [8:0]      row_k;
	logic [7:0]      mask_c;
	logic            full;
	logic            col_live;
	logic [AW-1:0]   addr_col;
	logic [7:0]      merged;

	function automatic logic [AW-1:0] addr_of(input logic [PG_W-1:0] pg,
		input logic [XS_W-1:0] col);
		logic [AW:0] prod;
		prod = (AW+1)'(pg) * (AW+1)'(SCREEN_COLUMNS) + (AW+1)'(col[CA_W-1:0]);
		return prod[AW-1:0];
	endfunction

	pgfs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign px_x       = XS_W'(px_q);
	assign x_sum      = px_x + XS_W'(sx_q);
	assign x_clip     = (x_sum > COLS_X) ? COLS_X : x_sum;
	assign y_sum      = {2'b00, py_q} + {2'b00, sy_q};
	assign y_clip     = (y_sum > ROWS9) ? ROWS9 : y_sum;
	assign y_last     = y_clip - 9'd1;
	assign pg7_first  = {2'b00, py_q[6:2]};
	assign pg7_last   = y_last[8:2];
	assign page_first = pg7_first[PG_W-1:0];
	assign on_screen  = (px_x < COLS_X) && ({2'b00, py_q} < ROWS9);
	assign empty      = !on_screen || (sx_q == 9'd0) || (sy_q == 7'd0);

	assign base_row = 9'({page_q, 2'b00});

	// page mask: row 4p+k owns bits 7-2k and 6-2k
	always_comb begin
		mask_c = 8'h00;
		row_k  = base_row;
		for (int k = 0; k < 4; k++) begin
			row_k = base_row + 9'(k);
			if (row_k >= {2'b00, py_q} && row_k < yend_q) begin
				mask_c[7-2*k -: 2] = 2'b11;
			end
		end
	end

	assign full     = (mask_q == 8'hFF);
	assign col_live = (col_q != xend_q);
	assign addr_col = addr_of(page_q, col_q);
	assign merged   = (ram_rdata & ~mask_q) | (pat_q & mask_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_col;
		ram_wdata = pat_q;
		ram_re    = 1'b0;
		ram_raddr = addr_col;
		unique case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = init_q ? 8'h00 : pat_q;
			end
			ST_FCOL: begin
				if (full) begin
					ram_we = col_live;
				end else begin
					// write back the byte read last cycle, read the next one
					ram_we    = pend_s1;
					ram_waddr = waddr_s1;
					ram_wdata = merged;
					ram_re    = col_live;
				end
			end
			ST_RD: begin
				ram_re    = on_screen;
				ram_raddr = addr_of(page_first, px_x);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q  <= 1'b1;
			clr_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q  <= cmd.op;
						px_q  <= cmd.pos_x;
						py_q  <= cmd.pos_y;
						pat_q <= pgfs_pkg::grey_byte(cmd.color);
						// a dot is a one by one fill
						sx_q  <= (cmd.op == pgfs_pkg::OP_DOT) ? 9'd1 : cmd.span_x;
						sy_q  <= (cmd.op == pgfs_pkg::OP_DOT) ? 7'd1 : cmd.span_y;
						unique case (cmd.op)
							pgfs_pkg::OP_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							pgfs_pkg::OP_READ: state_q <= ST_RD;
							default: state_q <= ST_FSET;
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_A) begin
						init_q  <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_FSET: begin
					xend_q  <= x_clip;
					yend_q  <= y_clip;
					page_q  <= page_first;
					pend_q  <= pg7_last[PG_W-1:0];
					state_q <= empty ? ST_DONE : ST_FPAGE;
				end
				ST_FPAGE: begin
					mask_q  <= mask_c;
					col_q   <= px_x;
					pend_s1 <= 1'b0;
					state_q <= ST_FCOL;
				end
				ST_FCOL: begin
					if (!full) begin
						pend_s1  <= col_live;
						waddr_s1 <= addr_col;
					end
					if (col_live) begin
						col_q <= col_q + XS_W'(1);
					end else if (page_q == pend_q) begin
						state_q <= ST_DONE;
					end else begin
						page_q  <= page_q + PG_W'(1);
						state_q <= ST_FPAGE;
					end
				end
				ST_RD: begin
					state_q <= ST_RCAP;
				end
				ST_RCAP: begin
					rbyte_q <= on_screen ? ram_rdata : 8'h00;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_byte  = (op_q == pgfs_pkg::OP_READ) ? rbyte_q : 8'h00;

endmodule

// ===== src/packed_grey_frame_store_engine_top.sv =====
`timescale 1ns / 1ps

// Packed 2-bit grey frame store, SCREEN_COLUMNS x 4*SCREEN_PAGES pixels, four
// pixels to a byte, top row of each page in bits 7:6.
// Input stream (s_*): one beat per operation, kind in s_tuser (clear, dot,
// fill, read), coordinates and color in s_tdata. Output stream (m_*): exactly
// one beat per operation, in order; read_byte is the stored byte for a read
// and zero otherwise, done_res is always one.
// One operation runs at a time over the single write port and single read
// port of the store memory. The result beat shows on m_* as s_tready rises.
// A fill walks its pages after clipping; partial pages use a pipelined
// read/merge/write, one byte a cycle. A clear writes one byte per cycle.
// After reset the store is zeroed by a sweep over all COLUMNS*PAGES bytes
// (6144 at defaults) during which s_tready stays low.
// A finished result sits in an output register; the next beat is accepted
// while it waits. If the receiver stalls further, the engine holds its
// finished result and stops taking beats until the register drains.

module packed_grey_frame_store_engine_top #(
	parameter int SCREEN_COLUMNS = pgfs_pkg::DEF_SCREEN_COLUMNS,
	parameter int SCREEN_PAGES   = pgfs_pkg::DEF_SCREEN_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pos_x[7:0], pos_y[14:8], span_x[23:15], span_y[30:24], color[32:31]
	input  logic [39:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_byte[7:0], done_res[8]
	output logic [15:0] m_tdata
);

	pgfs_pkg::cmd_t cmd;
	logic           res_valid;
	logic           res_ready;
	logic [7:0]     res_byte;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;

	assign cmd.op     = s_tuser;
	assign cmd.pos_x  = s_tdata[7:0];
	assign cmd.pos_y  = s_tdata[14:8];
	assign cmd.span_x = s_tdata[23:15];
	assign cmd.span_y = s_tdata[30:24];
	assign cmd.color  = s_tdata[32:31];

	pgfs_engine #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd       (cmd),
		.cmd_ready (s_tready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_byte  (res_byte)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_byte_q <= res_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, 1'b1, out_byte_q};

endmodule
